/* rtl/length_prefixed_packet_deframer_macros.svh */
// Assertion macros shared by the deframer RTL.
// In synthesis builds the macros expand to nothing.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define LPPD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("deframer assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define LPPD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`else

`define LPPD_ASSERT(name, clk, rst_n, prop)
`define LPPD_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/lppd_pkg.sv */
`default_nettype none

package lppd_pkg;

  // Longest length varint accepted, in bytes.
  localparam int MaxLenBytes  = 4;
  // Number of length bytes whose value bits are collected.
  localparam int AccumBytes   = 4;
  localparam int BitsPerByte  = 7;
  localparam int AccW         = 28;
  localparam int LenCntW      = $clog2(MaxLenBytes + 1);
  localparam int ShiftW       = 5;

  localparam logic [7:0] TagReset = 8'd10;

  typedef enum logic [1:0] {
    ErrNone = 2'd0,
    ErrTag  = 2'd1,
    ErrLong = 2'd2,
    ErrZero = 2'd3
  } lppd_err_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_packet;
    logic       last_of_packet;
    lppd_err_e  error_code;
  } lppd_result_t;

  // A byte handed from the input register to the framing logic.
  typedef struct packed {
    logic       valid;
    logic [7:0] stream_byte;
  } lppd_byte_t;

endpackage

`default_nettype wire

/* rtl/lppd_if.sv */
`default_nettype none

interface lppd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface lppd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       first_of_packet;
  logic       last_of_packet;
  logic [1:0] error_code;

  modport source (
    output valid, output payload_byte, output first_of_packet,
    output last_of_packet, output error_code, input ready
  );
  modport sink (
    input valid, input payload_byte, input first_of_packet,
    input last_of_packet, input error_code, output ready
  );
endinterface

`default_nettype wire

/* rtl/lppd_in_reg.sv */
`default_nettype none

module lppd_in_reg
  import lppd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lppd_in_if.sink   stream_i,
  input  wire logic advance_i,
  output lppd_byte_t held_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       take;

  // A new word may enter when the stage is empty or is being consumed.
  assign stream_i.ready = !valid_q || advance_i;
  assign take           = stream_i.valid && stream_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= stream_i.stream_byte;
    end
  end

  assign held_o.valid       = valid_q;
  assign held_o.stream_byte = byte_q;

endmodule

`default_nettype wire

/* rtl/lppd_core.sv */
`default_nettype none
`include "length_prefixed_packet_deframer_macros.svh"

module lppd_core
  import lppd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire lppd_byte_t held_i,
  input  wire logic   advance_i,
  input  wire logic [7:0] packet_tag_i,
  output logic        res_valid_o,
  output lppd_result_t res_o
);

  localparam logic [1:0] PhTag     = 2'd0;
  localparam logic [1:0] PhLen     = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;
  localparam logic [1:0] PhHunt    = 2'd3;

  logic [1:0]         phase_q, phase_d;
  logic [AccW-1:0]    acc_q, acc_d;
  logic [LenCntW-1:0] cnt_q, cnt_d;
  logic [AccW-1:0]    rem_q, rem_d;
  logic               first_q, first_d;

  logic [7:0]         b;
  logic [6:0]         bits;
  logic               is_tag;
  logic [ShiftW-1:0]  shamt;
  logic [AccW-1:0]    acc_new;
  logic [LenCntW-1:0] cnt_inc;
  logic               last_byte;

  assign b         = held_i.stream_byte;
  assign bits      = b[6:0];
  assign is_tag    = (b == packet_tag_i);
  assign shamt     = ShiftW'(BitsPerByte * 32'(cnt_q));
  assign acc_new   = acc_q | ({{(AccW - 7){1'b0}}, bits} << shamt);
  assign cnt_inc   = cnt_q + LenCntW'(1);
  assign last_byte = (rem_q <= AccW'(1));

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o       = '{payload_byte: 8'd0, first_of_packet: 1'b0,
                    last_of_packet: 1'b0, error_code: ErrNone};

    unique case (phase_q)
      PhTag: begin
        if (!is_tag) begin
          res_valid_o      = 1'b1;
          res_o.error_code = ErrTag;
          phase_d          = PhHunt;
        end else begin
          phase_d = PhLen;
        end
        acc_d = '0;
        cnt_d = '0;
      end
      PhHunt: begin
        if (is_tag) begin
          phase_d = PhLen;
          acc_d   = '0;
          cnt_d   = '0;
        end
      end
      PhLen: begin
        if (32'(cnt_q) >= AccumBytes && bits != 7'd0) begin
          res_valid_o      = 1'b1;
          res_o.error_code = ErrLong;
          phase_d          = PhHunt;
          acc_d            = '0;
          cnt_d            = '0;
        end else if (b[7]) begin
          if (32'(cnt_inc) >= MaxLenBytes) begin
            res_valid_o      = 1'b1;
            res_o.error_code = ErrLong;
            phase_d          = PhHunt;
            acc_d            = '0;
            cnt_d            = '0;
          end else begin
            if (32'(cnt_q) < AccumBytes) begin
              acc_d = acc_new;
            end
            cnt_d = cnt_inc;
          end
        end else begin
          if (32'(cnt_q) < AccumBytes) begin
            acc_d = acc_new;
          end
          if (acc_d == '0) begin
            res_valid_o      = 1'b1;
            res_o.error_code = ErrZero;
            phase_d          = PhHunt;
          end else begin
            rem_d   = acc_d;
            first_d = 1'b1;
            phase_d = PhPayload;
          end
          acc_d = '0;
          cnt_d = '0;
        end
      end
      PhPayload: begin
        res_valid_o           = 1'b1;
        res_o.payload_byte    = b;
        res_o.first_of_packet = first_q;
        res_o.last_of_packet  = last_byte;
        if (last_byte) begin
          rem_d   = '0;
          first_d = 1'b1;
          phase_d = PhTag;
        end else begin
          rem_d   = rem_q - AccW'(1);
          first_d = 1'b0;
        end
      end
      default: begin
        phase_d = PhTag;
      end
    endcase

    // Only a valid held byte produces a result.
    res_valid_o = res_valid_o && held_i.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhTag;
      acc_q   <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      first_q <= 1'b1;
    end else if (advance_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      first_q <= first_d;
    end
  end

  `LPPD_ASSERT(a_payload_has_bytes, clk_i, rst_ni, phase_q != PhPayload || rem_q != '0)
  `LPPD_ASSERT(a_len_count_bound, clk_i, rst_ni, 32'(cnt_q) < MaxLenBytes)
  `LPPD_ASSERT(a_error_is_clean, clk_i, rst_ni,
               !res_valid_o || res_o.error_code == ErrNone ||
               (res_o.payload_byte == 8'd0 && !res_o.first_of_packet &&
                !res_o.last_of_packet))
  `LPPD_ASSERT_NEXT(a_last_returns_to_tag, clk_i, rst_ni,
                    advance_i && phase_q == PhPayload && last_byte,
                    phase_q == PhTag && first_q)

endmodule

`default_nettype wire

/* rtl/lppd_out_reg.sv */
`default_nettype none

module lppd_out_reg
  import lppd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire lppd_result_t res_i,
  output logic         free_o,
  lppd_out_if.source   packet_o
);

  logic         valid_q, valid_d;
  lppd_result_t res_q;

  // The register can be refilled in the cycle its word is taken.
  assign free_o = !valid_q || packet_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (packet_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign packet_o.valid           = valid_q;
  assign packet_o.payload_byte    = res_q.payload_byte;
  assign packet_o.first_of_packet = res_q.first_of_packet;
  assign packet_o.last_of_packet  = res_q.last_of_packet;
  assign packet_o.error_code      = res_q.error_code;

endmodule

`default_nettype wire

/* rtl/length_prefixed_packet_deframer.sv */
// Length-prefixed packet deframer.
// stream_i carries the raw byte stream, one word per byte, under valid/ready.
// Each packet is a tag byte equal to the packet tag register, a little-endian
// base-128 varint length of at most four bytes, then that many payload bytes.
// packet_o carries one word per payload byte, flagged first and last of the
// packet. A wrong tag, an overlong length or a zero length gives one error
// word with a zero payload, after which the block hunts for the next tag.
// Header bytes and bytes dropped while hunting give no output word.
// A byte accepted on stream_i passes through an input register and a result
// register before it appears on packet_o. The block takes one byte per cycle
// while packet_o is not stalled, with combinational framing logic between
// those two registers.
// When the receiver stalls, the result register holds its word and the input
// register holds one more byte; stream_i.ready then falls until packet_o
// moves. A result register being emptied may be refilled in the same cycle.
// Reset (rst_ni low, asynchronous) empties both registers, returns the framer
// to expecting a tag and sets the packet tag to 10. The user must write the
// tag via tag_we_i/tag_wdata_i only while the block is idle (not enforced).
`default_nettype none

module length_prefixed_packet_deframer
  import lppd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  lppd_in_if.sink         stream_i,
  lppd_out_if.source      packet_o,
  input  wire logic       tag_we_i,
  input  wire logic [7:0] tag_wdata_i
);

  logic [7:0]   tag_q;
  lppd_byte_t   held;
  logic         out_free;
  logic         advance;
  logic         res_valid;
  lppd_result_t res;

  // Configuration register for the expected tag byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= TagReset;
    end else if (tag_we_i) begin
      tag_q <= tag_wdata_i;
    end
  end

  // The held byte is processed whenever the result register has room, so
  // a result is never lost even when the byte turns out to be a header byte.
  assign advance = held.valid && out_free;

  lppd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stream_i  (stream_i),
    .advance_i (advance),
    .held_o    (held)
  );

  lppd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .held_i       (held),
    .advance_i    (advance),
    .packet_tag_i (tag_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  lppd_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && res_valid),
    .res_i    (res),
    .free_o   (out_free),
    .packet_o (packet_o)
  );

endmodule

`default_nettype wire
